>>> rtl/boot_watchdog_with_action_timers_macros.svh
// assertion macros used by the checker file
`ifndef BOOT_WATCHDOG_WITH_ACTION_TIMERS_MACROS_SVH
`define BOOT_WATCHDOG_WITH_ACTION_TIMERS_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define BWAT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bwat assertion failed");

// next-cycle implication, sampled on clk, off while rst is high
`define BWAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bwat assertion failed");

`endif

>>> rtl/bwat_pkg.sv
// shared types, codes and helper functions of the boot watchdog
`timescale 1ns / 1ps

package bwat_pkg;

  localparam int SLOTS_DEFAULT = 16;

  // register indexes of the configuration port
  localparam logic [1:0] REG_LONG_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_SHORT_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_ACTION_MAX    = 2'd2;
  localparam logic [1:0] REG_CHECK_STEP    = 2'd3;

  localparam logic [31:0] LONG_TIMEOUT_RESET  = 32'd1800000;
  localparam logic [31:0] SHORT_TIMEOUT_RESET = 32'd600000;
  localparam logic [31:0] ACTION_MAX_RESET    = 32'd600000;
  localparam logic [15:0] CHECK_STEP_RESET    = 16'd5000;

  // request actions
  localparam logic [2:0] ACT_TICK        = 3'd0;
  localparam logic [2:0] ACT_SUSPEND     = 3'd1;
  localparam logic [2:0] ACT_RESUME      = 3'd2;
  localparam logic [2:0] ACT_SLOT_START  = 3'd3;
  localparam logic [2:0] ACT_SLOT_STOP   = 3'd4;
  localparam logic [2:0] ACT_SLOT_PAUSE  = 3'd5;
  localparam logic [2:0] ACT_SLOT_RESUME = 3'd6;
  localparam logic [2:0] ACT_STOP        = 3'd7;

  // result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_BOOT   = 2'd1;
  localparam logic [1:0] KIND_SLOT   = 2'd2;

  typedef struct packed {
    logic load;   // capture the request
    logic exec;   // run a command or the first step of a tick
    logic walk;   // step the slot walk
    logic chk;    // settle the check outcome
    logic emit;   // step the expiry emission
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic alive;
    logic tick_kill;
    logic out_free;
    logic walk_done;
    logic pend_any;
  } stat_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] a);
    logic [32:0] s;
    s = {1'b0, a} + 33'd1;
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] sat_add_step(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

>>> rtl/bwat_ctrl.sv
// sequencer of the boot watchdog: request intake, slot walk and expiry emission
`timescale 1ns / 1ps

module bwat_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  bwat_pkg::stat_t stat,
  output bwat_pkg::cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_WALK = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.is_tick) begin
          // a dead block ignores ticks
          if (stat.alive) begin
            cmd.exec   = 1'b1;
            state_next = stat.tick_kill ? ST_IDLE : ST_WALK;
          end else begin
            state_next = ST_IDLE;
          end
        end else if (stat.out_free) begin
          cmd.exec   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_done) begin
          state_next = ST_CHK;
        end
      end
      ST_CHK: begin
        cmd.chk    = 1'b1;
        state_next = stat.pend_any ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (stat.pend_any) begin
          cmd.emit = 1'b1;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/bwat_dp.sv
// datapath of the boot watchdog: timers, slot store, expiry flags and result register
`timescale 1ns / 1ps

module bwat_dp #(
  parameter int SLOTS = bwat_pkg::SLOTS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  bwat_pkg::cmd_t  cmd,
  output bwat_pkg::stat_t stat,
  input  logic [2:0]      action,
  input  logic [3:0]      slot,
  input  logic [31:0]     timeout_ms,
  input  logic            cfg_valid,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      kind,
  output logic            ok,
  output logic            long_cause,
  output logic [3:0]      expired_slot,
  output logic            short_enabled,
  output logic [31:0]     short_elapsed_ms,
  output logic            last_result
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW = $clog2(SLOTS + 1);

  // configuration
  logic [31:0] long_to;
  logic [31:0] short_to;
  logic [31:0] act_max;
  logic [15:0] check_step;

  // captured request
  logic [2:0]  act_r;
  logic [3:0]  slot_r;
  logic [31:0] tmo_r;

  // watchdog state
  logic        alive;
  logic        running;
  logic        short_on;
  logic [31:0] short_count;
  logic [31:0] long_count;
  logic [15:0] step_phase;
  logic [SLOTS-1:0] active_v;
  logic [SLOTS-1:0] paused_v;

  // slot store: count in the upper half, limit in the lower half
  logic [63:0] slot_mem [SLOTS];
  logic [63:0] rdata;
  logic        mem_we;
  logic [IW-1:0] mem_waddr;
  logic [63:0] mem_wdata;
  logic        rd_en;

  // walk and emission
  logic          proc_v;
  logic [IW-1:0] proc_idx;
  logic [EW-1:0] walk_idx;
  logic [EW-1:0] eidx;
  logic          check_r;
  logic [SLOTS:0] pend;
  logic [SLOTS:0] pend_clr;
  logic          boot_long;

  // command decode
  logic [IW-1:0] sidx;
  logic          slot_ok;
  logic          cur_active;
  logic          cur_paused;
  logic          others_active;
  logic [SLOTS-1:0] act_excl;
  logic          exec_cmd;
  logic          tick0;
  logic          cmd_ok;
  logic          son_nx;
  logic          set_active;
  logic          set_paused;
  logic          set_free;
  logic          start_wr;
  logic          stop_run;
  logic [31:0]   lim_new;

  // tick step
  logic [15:0] ph1;
  logic        check_now;

  // slot processing
  logic [31:0] cnt_new;
  logic        proc_active;
  logic        proc_hit;
  logic [EW-1:0] hit_pos;

  logic out_free;
  logic emit_fire;

  assign out_free  = !out_valid || out_ready;
  assign exec_cmd  = cmd.exec && (act_r != bwat_pkg::ACT_TICK);
  assign tick0     = cmd.exec && (act_r == bwat_pkg::ACT_TICK) && alive;

  assign ph1       = step_phase + 16'd1;
  assign check_now = ph1 >= check_step;

  assign sidx       = IW'(slot_r);
  assign slot_ok    = alive && (int'(slot_r) < SLOTS);
  assign cur_active = slot_ok && active_v[sidx];
  assign cur_paused = slot_ok && paused_v[sidx];
  assign lim_new    = (tmo_r > act_max) ? act_max : tmo_r;

  always_comb begin
    act_excl = active_v;
    if (slot_ok) begin
      act_excl[sidx] = 1'b0;
    end
    others_active = |act_excl;
  end

  always_comb begin
    cmd_ok     = 1'b0;
    son_nx     = short_on;
    set_active = 1'b0;
    set_paused = 1'b0;
    set_free   = 1'b0;
    start_wr   = 1'b0;
    stop_run   = 1'b0;
    case (act_r)
      bwat_pkg::ACT_SUSPEND: begin
        if (alive && short_on) begin
          cmd_ok = 1'b1;
          son_nx = 1'b0;
        end
      end
      bwat_pkg::ACT_RESUME: begin
        if (alive && !short_on) begin
          cmd_ok = 1'b1;
          son_nx = 1'b1;
        end
      end
      bwat_pkg::ACT_SLOT_START: begin
        if (slot_ok && !cur_active && !cur_paused) begin
          set_active = 1'b1;
          start_wr   = 1'b1;
          // ok only when the short timer gets switched off by this start
          cmd_ok     = short_on;
          son_nx     = 1'b0;
        end
      end
      bwat_pkg::ACT_SLOT_STOP: begin
        if (slot_ok) begin
          set_free = 1'b1;
          cmd_ok   = 1'b1;
          if (!others_active) begin
            son_nx = 1'b1;
          end
        end
      end
      bwat_pkg::ACT_SLOT_PAUSE: begin
        if (cur_active) begin
          set_paused = 1'b1;
          cmd_ok     = 1'b1;
          if (!others_active) begin
            son_nx = 1'b1;
          end
        end
      end
      bwat_pkg::ACT_SLOT_RESUME: begin
        if (cur_paused) begin
          set_active = 1'b1;
          cmd_ok     = 1'b1;
          son_nx     = 1'b0;
        end
      end
      bwat_pkg::ACT_STOP: begin
        if (alive) begin
          stop_run = 1'b1;
          cmd_ok   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // slot processing stage of the walk
  assign cnt_new     = bwat_pkg::sat_inc(rdata[63:32]);
  assign proc_active = proc_v && active_v[proc_idx];
  assign proc_hit    = proc_active && check_r && (cnt_new >= rdata[31:0]);
  assign hit_pos     = EW'(proc_idx) + EW'(1);

  assign rd_en     = cmd.walk && (walk_idx != EW'(SLOTS));
  assign mem_we    = (exec_cmd && start_wr) || proc_active;
  assign mem_waddr = (exec_cmd && start_wr) ? sidx : proc_idx;
  assign mem_wdata = (exec_cmd && start_wr) ? {32'd0, lim_new} : {cnt_new, rdata[31:0]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= slot_mem[walk_idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proc_v <= 1'b0;
    end else begin
      proc_v <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      proc_idx <= walk_idx[IW-1:0];
    end
  end

  always_comb begin
    pend_clr       = pend;
    pend_clr[eidx] = 1'b0;
  end

  assign emit_fire = cmd.emit && pend[eidx] && out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      long_to    <= bwat_pkg::LONG_TIMEOUT_RESET;
      short_to   <= bwat_pkg::SHORT_TIMEOUT_RESET;
      act_max    <= bwat_pkg::ACTION_MAX_RESET;
      check_step <= bwat_pkg::CHECK_STEP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        bwat_pkg::REG_LONG_TIMEOUT:  long_to    <= cfg_data;
        bwat_pkg::REG_SHORT_TIMEOUT: short_to   <= cfg_data;
        bwat_pkg::REG_ACTION_MAX:    act_max    <= cfg_data;
        bwat_pkg::REG_CHECK_STEP:    check_step <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= action;
      slot_r <= slot;
      tmo_r  <= timeout_ms;
    end
  end

  // watchdog state
  always_ff @(posedge clk) begin
    if (rst) begin
      alive       <= 1'b1;
      running     <= 1'b1;
      short_on    <= 1'b1;
      short_count <= 32'd0;
      long_count  <= 32'd0;
      step_phase  <= 16'd0;
      active_v    <= '0;
      paused_v    <= '0;
      check_r     <= 1'b0;
      pend        <= '0;
      boot_long   <= 1'b0;
      walk_idx    <= '0;
      eidx        <= '0;
    end else begin
      if (exec_cmd) begin
        short_on <= son_nx;
        if (stop_run) begin
          running <= 1'b0;
        end
        if (set_active) begin
          active_v[sidx] <= 1'b1;
          paused_v[sidx] <= 1'b0;
        end
        if (set_paused) begin
          active_v[sidx] <= 1'b0;
          paused_v[sidx] <= 1'b1;
        end
        if (set_free) begin
          active_v[sidx] <= 1'b0;
          paused_v[sidx] <= 1'b0;
        end
      end

      if (tick0) begin
        if (short_on) begin
          short_count <= bwat_pkg::sat_inc(short_count);
        end
        step_phase <= check_now ? 16'd0 : ph1;
        walk_idx   <= '0;
        eidx       <= '0;
        pend       <= '0;
        if (check_now && !running) begin
          // a check after a stop or an expiry kills the block
          alive    <= 1'b0;
          active_v <= '0;
          paused_v <= '0;
          check_r  <= 1'b0;
        end else begin
          check_r <= check_now;
          if (check_now) begin
            long_count <= bwat_pkg::sat_add_step(long_count, check_step);
          end
        end
      end

      if (cmd.walk) begin
        if (rd_en) begin
          walk_idx <= walk_idx + EW'(1);
        end
        // boot timers are judged first so that their result leads
        if (walk_idx == '0 && check_r) begin
          pend[0]   <= (long_count >= long_to) || (short_count >= short_to);
          boot_long <= long_count >= long_to;
        end
      end
      if (proc_hit) begin
        pend[hit_pos] <= 1'b1;
      end

      if (cmd.chk && (|pend)) begin
        running <= 1'b0;
      end

      if (cmd.emit) begin
        if (pend[eidx]) begin
          if (out_free) begin
            pend <= pend_clr;
            eidx <= eidx + EW'(1);
          end
        end else begin
          eidx <= eidx + EW'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_cmd || emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_cmd) begin
      kind             <= bwat_pkg::KIND_STATUS;
      ok               <= cmd_ok;
      long_cause       <= 1'b0;
      expired_slot     <= 4'd0;
      short_enabled    <= alive && son_nx;
      short_elapsed_ms <= short_count;
      last_result      <= 1'b1;
    end else if (emit_fire) begin
      kind             <= (eidx == '0) ? bwat_pkg::KIND_BOOT : bwat_pkg::KIND_SLOT;
      ok               <= 1'b1;
      long_cause       <= (eidx == '0) && boot_long;
      expired_slot     <= (eidx == '0) ? 4'd0 : 4'(eidx - EW'(1));
      short_enabled    <= alive && short_on;
      short_elapsed_ms <= short_count;
      last_result      <= (pend_clr == '0);
    end
  end

  assign stat.is_tick   = (act_r == bwat_pkg::ACT_TICK);
  assign stat.alive     = alive;
  assign stat.tick_kill = check_now && !running;
  assign stat.out_free  = out_free;
  assign stat.walk_done = (walk_idx == EW'(SLOTS));
  assign stat.pend_any  = |pend;

endmodule

>>> rtl/boot_watchdog_with_action_timers.sv
// Boot watchdog with a long timer, a suspendable short timer and SLOTS action
// timers, advanced by one-millisecond tick requests. A command request (actions
// 1 to 7) puts its status result into the output register from the execute
// state that follows acceptance, later if that register is still held by the
// consumer, and the next request is taken once the block is back in idle.
// A tick on a live block, unless its check kills the block, walks the slot
// store, one slot per cycle through its separate read and write ports; a tick
// that runs a check and finds expiries then sends its results, at most one per
// cycle while the output is free, stepping over the slots in order. Ticks on a
// dead block return to idle from the execute state. Slot states live in
// flip-flops cleared by reset, so no clearing pass follows reset.
// Configuration writes are taken on every cycle.
`timescale 1ns / 1ps

module boot_watchdog_with_action_timers #(
  parameter int SLOTS = bwat_pkg::SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [3:0]  slot,
  input  logic [31:0] timeout_ms,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic        ok,
  output logic        long_cause,
  output logic [3:0]  expired_slot,
  output logic        short_enabled,
  output logic [31:0] short_elapsed_ms,
  output logic        last_result
);

  bwat_pkg::cmd_t  cmd;
  bwat_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  bwat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bwat_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .action           (action),
    .slot             (slot),
    .timeout_ms       (timeout_ms),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .kind             (kind),
    .ok               (ok),
    .long_cause       (long_cause),
    .expired_slot     (expired_slot),
    .short_enabled    (short_enabled),
    .short_elapsed_ms (short_elapsed_ms),
    .last_result      (last_result)
  );

endmodule

>>> rtl/bwat_checker.sv
// port-level checker of the boot watchdog and its bind to the top level
`timescale 1ns / 1ps
`include "boot_watchdog_with_action_timers_macros.svh"

module bwat_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic        ok,
  input logic        long_cause,
  input logic [3:0]  expired_slot,
  input logic        short_enabled,
  input logic [31:0] short_elapsed_ms,
  input logic        last_result
);

  logic [41:0] out_word;

  assign out_word = {kind, ok, long_cause, expired_slot, short_enabled,
                     short_elapsed_ms, last_result};

  // a result waiting for the consumer stays put
  `BWAT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))
  // one request at a time: intake closes right after an acceptance
  `BWAT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // expiry results always report success
  `BWAT_ASSERT_NOW(a_expiry_ok, out_valid && kind != bwat_pkg::KIND_STATUS, ok)
  // a command gives a single status result
  `BWAT_ASSERT_NOW(a_status_last, out_valid && kind == bwat_pkg::KIND_STATUS, last_result)

endmodule

bind boot_watchdog_with_action_timers bwat_checker u_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .kind             (kind),
  .ok               (ok),
  .long_cause       (long_cause),
  .expired_slot     (expired_slot),
  .short_enabled    (short_enabled),
  .short_elapsed_ms (short_elapsed_ms),
  .last_result      (last_result)
);
